// File: hw/rtl/dnsw_pkg.sv
// Shared types and constants for the DNS name to wire-format encoder.
// No dependencies; every other file of the block refers to this package.
package dnsw_pkg;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHR_END    = 8'h00;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_HYPHEN = 8'h2D;

    // Widths fixed by the largest label (63) and the largest name (255).
    localparam int LEN_W  = 6;
    localparam int WC_W   = 8;
    localparam int ADDR_W = LEN_W + 1;

    // Error codes carried on the result stream.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BADCHAR = 3'd1;
    localparam logic [2:0] ERR_LABEL   = 3'd2;
    localparam logic [2:0] ERR_NAME    = 3'd3;
    localparam logic [2:0] ERR_END     = 3'd4;
    localparam logic [2:0] ERR_EMPTY   = 3'd5;

    // Command kinds passed from the front end to the emitter.
    localparam logic [1:0] CMD_LABEL = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_ERR   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       err;
        logic             bank;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // Write port into the label buffer.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_port_t;

    // Emitter hands a label bank back to the front end.
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

endpackage

// File: hw/rtl/dns_name_to_wire_encoder.sv
// Top level of the DNS name to wire-format encoder: front end, command
// queue and emitter. Depends on dnsw_pkg, dnsw_front, dnsw_cmdq, dnsw_back.
//
//  channel  | direction | beat content
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tdata[7:0] char_in
//  m_*      | out       | tdata[7:0] wire_byte, tlast last_of_run,
//           |           | tuser[0] name_done, tuser[3:1] error_code
//
// Characters are taken one a cycle while the command queue (two entries)
// has room and the label bank being filled is not still being emitted.
// A label of n characters leaves as n+1 beats: the length byte, then
// each label byte after a buffer read and an output register load.
// The closing zero and error beats are a single beat each.
// Reset is asynchronous and clears all control state; there is no
// clearing pass. Either side may stall at any time without loss.
module dns_name_to_wire_encoder #(
    parameter int LABEL_MAX = 63,
    parameter int NAME_MAX  = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] wire_byte
    output logic       m_tlast,
    output logic [3:0] m_tuser    // [0] name_done, [3:1] error_code
);

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    dnsw_pkg::cmd_t     q_cmd;
    dnsw_pkg::cmd_t     q_head;
    dnsw_pkg::wr_port_t wr;
    dnsw_pkg::release_t rel;

    dnsw_front #(
        .LABEL_MAX (LABEL_MAX),
        .NAME_MAX  (NAME_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .wr       (wr),
        .rel      (rel)
    );

    dnsw_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    dnsw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .wr       (wr),
        .rel      (rel),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/dnsw_front.sv
// Front end: accepts characters, checks them, buffers label bytes and
// queues emit commands. Depends on dnsw_pkg.
module dnsw_front #(
    parameter int LABEL_MAX = 63,
    parameter int NAME_MAX  = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output dnsw_pkg::cmd_t      q_cmd,
    output dnsw_pkg::wr_port_t  wr,
    input  dnsw_pkg::release_t  rel
);

    localparam int LEN_W = dnsw_pkg::LEN_W;

    logic [dnsw_pkg::LEN_W-1:0] len_reg, len_next;
    logic [dnsw_pkg::WC_W-1:0]  wc_reg, wc_next;
    logic                       seen_reg, seen_next;
    logic                       disc_reg, disc_next;
    logic                       wbank_reg, wbank_next;
    logic [1:0]                 busy_reg, busy_next;

    logic                       accept;
    logic                       fault;
    logic                       at_end;
    logic [2:0]                 err;
    logic [8:0]                 name_sum;
    logic [8:0]                 wc_sum;
    logic                       name_char;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == dnsw_pkg::CHR_HYPHEN);
    endfunction

    // A new character may need a queue slot, and label bytes need a free bank.
    assign s_tready  = !q_full && !busy_reg[wbank_reg];
    assign accept    = s_tvalid && s_tready;
    assign name_char = is_name_char(s_tdata);
    assign name_sum  = {1'b0, wc_reg} + {3'b000, len_reg} + 9'd2;
    assign wc_sum    = name_sum - 9'd1;

    always_comb
    begin
        len_next   = len_reg;
        wc_next    = wc_reg;
        seen_next  = seen_reg;
        disc_next  = disc_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        wr         = '0;
        fault      = 1'b0;
        at_end     = 1'b0;
        err        = dnsw_pkg::ERR_NONE;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (disc_reg)
            begin
                if (s_tdata == dnsw_pkg::CHR_END)
                begin
                    disc_next = 1'b0;
                    len_next  = '0;
                    wc_next   = '0;
                    seen_next = 1'b0;
                end
            end
            else if (name_char)
            begin
                if (len_reg >= LEN_W'(LABEL_MAX))
                begin
                    fault = 1'b1;
                    err   = dnsw_pkg::ERR_LABEL;
                end
                else
                begin
                    wr.en    = 1'b1;
                    wr.addr  = {wbank_reg, len_reg};
                    wr.data  = s_tdata;
                    len_next = len_reg + 1'b1;
                end
            end
            else if (s_tdata == dnsw_pkg::CHR_DOT)
            begin
                if (len_reg == '0)
                begin
                    fault = 1'b1;
                    err   = dnsw_pkg::ERR_EMPTY;
                end
                else if (name_sum > 9'(NAME_MAX))
                begin
                    fault = 1'b1;
                    err   = dnsw_pkg::ERR_NAME;
                end
                else
                begin
                    q_push               = 1'b1;
                    q_cmd.kind           = dnsw_pkg::CMD_LABEL;
                    q_cmd.bank           = wbank_reg;
                    q_cmd.len            = len_reg;
                    busy_next[wbank_reg] = 1'b1;
                    wbank_next           = !wbank_reg;
                    wc_next              = wc_sum[dnsw_pkg::WC_W-1:0];
                    seen_next            = 1'b1;
                    len_next             = '0;
                end
            end
            else if (s_tdata == dnsw_pkg::CHR_END)
            begin
                if (len_reg != '0 || !seen_reg)
                begin
                    fault  = 1'b1;
                    at_end = 1'b1;
                    err    = dnsw_pkg::ERR_END;
                end
                else
                begin
                    q_push     = 1'b1;
                    q_cmd.kind = dnsw_pkg::CMD_END;
                    len_next   = '0;
                    wc_next    = '0;
                    seen_next  = 1'b0;
                end
            end
            else
            begin
                fault = 1'b1;
                err   = dnsw_pkg::ERR_BADCHAR;
            end

            if (fault)
            begin
                q_push     = 1'b1;
                q_cmd.kind = dnsw_pkg::CMD_ERR;
                q_cmd.err  = err;
                len_next   = '0;
                wc_next    = '0;
                seen_next  = 1'b0;
                disc_next  = !at_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            wc_reg    <= '0;
            seen_reg  <= 1'b0;
            disc_reg  <= 1'b0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            wc_reg    <= wc_next;
            seen_reg  <= seen_next;
            disc_reg  <= disc_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_label_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(LABEL_MAX))
        else $error("buffered label longer than the limit");

    a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wc_reg} < 9'(NAME_MAX))
        else $error("wire count reached the name limit");

    a_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !busy_reg[wr.addr[dnsw_pkg::ADDR_W-1]])
        else $error("label byte written into a bank still being emitted");

endmodule

// File: hw/rtl/dnsw_cmdq.sv
// Two-entry command queue between the front end and the emitter.
// Depends on dnsw_pkg for the command type.
module dnsw_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dnsw_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output dnsw_pkg::cmd_t head
);

    dnsw_pkg::cmd_t entry_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = !wptr_reg;
        end
        if (pop)
        begin
            rptr_next = !rptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/dnsw_back.sv
// Emitter: takes queued commands and drives result beats, reading label
// bytes from a two-bank buffer it owns. Depends on dnsw_pkg.
module dnsw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dnsw_pkg::cmd_t      q_head,
    output logic                q_pop,
    input  dnsw_pkg::wr_port_t  wr,
    output dnsw_pkg::release_t  rel,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [3:0]          m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int MEM_DEPTH = 2 << dnsw_pkg::LEN_W;

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    logic [1:0]                 state_reg, state_next;
    logic                       bank_reg, bank_next;
    logic [dnsw_pkg::LEN_W-1:0] len_reg, len_next;
    logic [dnsw_pkg::LEN_W-1:0] idx_reg, idx_next;
    logic                       ov_reg, ov_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       done_reg, done_next;
    logic [2:0]                 err_reg, err_next;

    logic                       can_load;
    logic                       last_byte;

    assign can_load  = !ov_reg || m_tready;
    assign last_byte = (idx_reg + 1'b1) == len_reg;

    assign m_tvalid = ov_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {err_reg, done_reg};

    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !m_tready;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        err_next   = err_reg;
        q_pop      = 1'b0;
        rel        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && can_load)
                begin
                    q_pop     = 1'b1;
                    ov_next   = 1'b1;
                    done_next = 1'b0;
                    err_next  = dnsw_pkg::ERR_NONE;
                    case (q_head.kind)
                        dnsw_pkg::CMD_LABEL:
                        begin
                            // Length byte first; the label bytes follow.
                            byte_next  = {2'b00, q_head.len};
                            last_next  = 1'b0;
                            bank_next  = q_head.bank;
                            len_next   = q_head.len;
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                        dnsw_pkg::CMD_END:
                        begin
                            byte_next = 8'h00;
                            last_next = 1'b1;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            byte_next = 8'h00;
                            last_next = 1'b1;
                            err_next  = q_head.err;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    ov_next   = 1'b1;
                    byte_next = rdata_reg;
                    last_next = last_byte;
                    done_next = 1'b0;
                    err_next  = dnsw_pkg::ERR_NONE;
                    if (last_byte)
                    begin
                        rel.valid  = 1'b1;
                        rel.bank   = bank_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (state_reg == S_READ)
        begin
            rdata_reg <= mem[{bank_reg, idx_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
        err_reg  <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && done_reg) |->
            (last_reg && byte_reg == 8'h00 && err_reg == dnsw_pkg::ERR_NONE))
        else $error("closing beat of a name is malformed");

    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && err_reg != dnsw_pkg::ERR_NONE) |-> (last_reg && byte_reg == 8'h00))
        else $error("error beat is not a single zero beat");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_EMIT))
        else $error("buffer read not followed by an emit step");

endmodule
